### sv/rtsd_pkg.sv
// Shared types and constants of the run-length token stream decoder.
package rtsd_pkg;

  localparam int unsigned CmdQueueDepth = 4;
  localparam int unsigned HeaderBytes   = 9;
  localparam int unsigned MinRunMulti   = 6;
  localparam int unsigned MinRunSingle  = 4;
  localparam int unsigned ApbAddrW      = 3;
  localparam int unsigned ApbDataW      = 32;

  localparam logic [7:0] ModeMulti  = 8'd0;
  localparam logic [7:0] ModeSingle = 8'd1;

  // Register map, word index on the configuration port.
  localparam logic RegOutputCapacity = 1'b0;
  localparam logic RegInputCapacity  = 1'b1;

  typedef enum logic [1:0] {
    KIND_LIT = 2'd0,
    KIND_RUN = 2'd1,
    KIND_END = 2'd2,
    KIND_ERR = 2'd3
  } token_kind_e;

  // What one parsed byte asks of the back end.
  typedef enum logic [2:0] {
    OP_LIT     = 3'd0,
    OP_LIT_RUN = 3'd1,
    OP_LIT_END = 3'd2,
    OP_RUN     = 3'd3,
    OP_END     = 3'd4,
    OP_ERR     = 3'd5
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [7:0]  lit;
    logic [7:0]  sym;
    logic [31:0] count;
    logic        single;
    logic [31:0] total;
  } cmd_t;

endpackage

### sv/rtsd_front.sv
// Stream parser: header, block fields and literal counting, one byte per cycle while accept_i is high.
module rtsd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               stream_start_i,
  input  logic [31:0]        output_capacity_i,
  input  logic [31:0]        input_capacity_i,
  output logic               cmd_valid_o,
  output rtsd_pkg::cmd_t     cmd_o
);

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_HEADER = 9'b000000010,
    PH_FIXSYM = 9'b000000100,
    PH_BSYM   = 9'b000001000,
    PH_CNT    = 9'b000010000,
    PH_CNT32  = 9'b000100000,
    PH_OFF    = 9'b001000000,
    PH_OFF32  = 9'b010000000,
    PH_LIT    = 9'b100000000
  } phase_e;

  phase_e      phase_q, phase_d, phase_e_s;
  logic [3:0]  pos_q, pos_d, pos_e;
  logic        single_q, single_d, single_e;
  logic [7:0]  fixsym_q, fixsym_d, fixsym_e;
  logic [7:0]  bsym_q, bsym_d, bsym_e;
  logic [31:0] count_q, count_d, count_e;
  logic [31:0] gather_q, gather_d, gather_e;
  logic [31:0] litleft_q, litleft_d, litleft_e;
  logic [31:0] hout_q, hout_d, hout_e;
  logic [31:0] hin_q, hin_d, hin_e;

  logic        valid;
  rtsd_pkg::cmd_op_e op;
  logic [31:0] word;
  phase_e      block_start;

  always_comb begin
    // A start byte drops whatever was in progress.
    if (stream_start_i) begin
      phase_e_s = PH_HEADER;
      pos_e     = '0;
      single_e  = 1'b0;
      fixsym_e  = '0;
      bsym_e    = '0;
      count_e   = '0;
      gather_e  = '0;
      litleft_e = '0;
      hout_e    = '0;
      hin_e     = '0;
    end else begin
      phase_e_s = phase_q;
      pos_e     = pos_q;
      single_e  = single_q;
      fixsym_e  = fixsym_q;
      bsym_e    = bsym_q;
      count_e   = count_q;
      gather_e  = gather_q;
      litleft_e = litleft_q;
      hout_e    = hout_q;
      hin_e     = hin_q;
    end
  end

  assign word        = {in_byte_i, gather_e[23:0]};
  assign block_start = single_e ? PH_CNT : PH_BSYM;

  always_comb begin
    phase_d   = phase_e_s;
    pos_d     = pos_e;
    single_d  = single_e;
    fixsym_d  = fixsym_e;
    bsym_d    = bsym_e;
    count_d   = count_e;
    gather_d  = gather_e;
    litleft_d = litleft_e;
    hout_d    = hout_e;
    hin_d     = hin_e;
    valid     = 1'b0;
    op        = rtsd_pkg::OP_ERR;
    unique case (phase_e_s)
      PH_HEADER: begin
        if (pos_e < 4'd4) begin
          hout_d[{pos_e[1:0], 3'b000} +: 8] = in_byte_i;
          pos_d = pos_e + 4'd1;
        end else if (pos_e < 4'(rtsd_pkg::HeaderBytes - 1)) begin
          hin_d[{pos_e[1:0], 3'b000} +: 8] = in_byte_i;
          pos_d = pos_e + 4'd1;
        end else begin
          pos_d = '0;
          if (hout_e > output_capacity_i || hin_e > input_capacity_i ||
              (in_byte_i != rtsd_pkg::ModeMulti && in_byte_i != rtsd_pkg::ModeSingle)) begin
            phase_d = PH_IDLE;
            valid   = 1'b1;
            op      = rtsd_pkg::OP_ERR;
          end else begin
            single_d = (in_byte_i == rtsd_pkg::ModeSingle);
            phase_d  = (in_byte_i == rtsd_pkg::ModeSingle) ? PH_FIXSYM : PH_BSYM;
          end
        end
      end
      PH_FIXSYM: begin
        fixsym_d = in_byte_i;
        phase_d  = PH_CNT;
      end
      PH_BSYM: begin
        bsym_d  = in_byte_i;
        phase_d = PH_CNT;
      end
      PH_CNT: begin
        if (in_byte_i != 8'd0) begin
          count_d = {24'd0, in_byte_i};
          phase_d = PH_OFF;
        end else begin
          gather_d = '0;
          pos_d    = '0;
          phase_d  = PH_CNT32;
        end
      end
      PH_CNT32: begin
        gather_d[{pos_e[1:0], 3'b000} +: 8] = in_byte_i;
        pos_d = pos_e + 4'd1;
        if (pos_e[1:0] == 2'd3) begin
          pos_d   = '0;
          count_d = word;
          phase_d = PH_OFF;
        end
      end
      PH_OFF: begin
        if (in_byte_i == 8'd1) begin
          // No literals: the block ends right here.
          valid = 1'b1;
          if (count_e == '0) begin
            op      = rtsd_pkg::OP_END;
            phase_d = PH_IDLE;
          end else begin
            op      = rtsd_pkg::OP_RUN;
            phase_d = block_start;
          end
        end else if (in_byte_i != 8'd0) begin
          litleft_d = {24'd0, in_byte_i - 8'd1};
          phase_d   = PH_LIT;
        end else begin
          gather_d = '0;
          pos_d    = '0;
          phase_d  = PH_OFF32;
        end
      end
      PH_OFF32: begin
        gather_d[{pos_e[1:0], 3'b000} +: 8] = in_byte_i;
        pos_d = pos_e + 4'd1;
        if (pos_e[1:0] == 2'd3) begin
          pos_d = '0;
          if (word == '0) begin
            // Zero long offset closes the stream at once.
            valid   = 1'b1;
            op      = rtsd_pkg::OP_END;
            phase_d = PH_IDLE;
          end else if (word == 32'd1) begin
            valid = 1'b1;
            if (count_e == '0) begin
              op      = rtsd_pkg::OP_END;
              phase_d = PH_IDLE;
            end else begin
              op      = rtsd_pkg::OP_RUN;
              phase_d = block_start;
            end
          end else begin
            litleft_d = word - 32'd1;
            phase_d   = PH_LIT;
          end
        end
      end
      PH_LIT: begin
        valid = 1'b1;
        if (litleft_e <= 32'd1) begin
          litleft_d = '0;
          if (count_e == '0) begin
            op      = rtsd_pkg::OP_LIT_END;
            phase_d = PH_IDLE;
          end else begin
            op      = rtsd_pkg::OP_LIT_RUN;
            phase_d = block_start;
          end
        end else begin
          op        = rtsd_pkg::OP_LIT;
          litleft_d = litleft_e - 32'd1;
        end
      end
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  assign cmd_valid_o   = accept_i && valid;
  assign cmd_o.op      = op;
  assign cmd_o.lit     = in_byte_i;
  assign cmd_o.sym     = single_e ? fixsym_e : bsym_e;
  assign cmd_o.count   = count_e;
  assign cmd_o.single  = single_e;
  assign cmd_o.total   = hout_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pos_q     <= '0;
      single_q  <= 1'b0;
      fixsym_q  <= '0;
      bsym_q    <= '0;
      count_q   <= '0;
      gather_q  <= '0;
      litleft_q <= '0;
      hout_q    <= '0;
      hin_q     <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      single_q  <= single_d;
      fixsym_q  <= fixsym_d;
      bsym_q    <= bsym_d;
      count_q   <= count_d;
      gather_q  <= gather_d;
      litleft_q <= litleft_d;
      hout_q    <= hout_d;
      hin_q     <= hin_d;
    end
  end

endmodule

### sv/rtsd_cmd_fifo.sv
// Short command queue between the parser and the token builder.
module rtsd_cmd_fifo #(
  parameter int unsigned Depth = rtsd_pkg::CmdQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  rtsd_pkg::cmd_t wr_data_i,
  input  logic           rd_en_i,
  output rtsd_pkg::cmd_t rd_data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rtsd_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### sv/rtsd_back.sv
// Token builder: turns commands into one or two result items behind an output register.
module rtsd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  rtsd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [1:0]     token_kind_o,
  output logic [7:0]     byte_value_o,
  output logic [32:0]    run_length_o,
  output logic [31:0]    total_length_o,
  output logic           last_of_step_o
);

  logic        out_valid_q, out_valid_d;
  logic        sub_q, sub_d;
  logic        load, two;
  rtsd_pkg::token_kind_e kind;
  logic [7:0]  byte_v;
  logic [32:0] run_v, bias;
  logic [31:0] total_v;

  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic [32:0] run_q;
  logic [31:0] total_q;
  logic        last_q;

  assign two  = (cmd_i.op == rtsd_pkg::OP_LIT_RUN) || (cmd_i.op == rtsd_pkg::OP_LIT_END);
  assign bias = cmd_i.single ? 33'(rtsd_pkg::MinRunSingle - 1) : 33'(rtsd_pkg::MinRunMulti - 1);

  always_comb begin
    unique case (cmd_i.op)
      rtsd_pkg::OP_LIT:     kind = rtsd_pkg::KIND_LIT;
      rtsd_pkg::OP_LIT_RUN: kind = sub_q ? rtsd_pkg::KIND_RUN : rtsd_pkg::KIND_LIT;
      rtsd_pkg::OP_LIT_END: kind = sub_q ? rtsd_pkg::KIND_END : rtsd_pkg::KIND_LIT;
      rtsd_pkg::OP_RUN:     kind = rtsd_pkg::KIND_RUN;
      rtsd_pkg::OP_END:     kind = rtsd_pkg::KIND_END;
      default:              kind = rtsd_pkg::KIND_ERR;
    endcase
  end

  always_comb begin
    byte_v  = '0;
    run_v   = '0;
    total_v = '0;
    unique case (kind)
      rtsd_pkg::KIND_LIT: byte_v = cmd_i.lit;
      rtsd_pkg::KIND_RUN: begin
        byte_v = cmd_i.sym;
        run_v  = {1'b0, cmd_i.count} + bias;
      end
      rtsd_pkg::KIND_END: total_v = cmd_i.total;
      default: ;
    endcase
  end

  // Load a new item whenever a command is waiting and the output register is free or being drained.
  assign load      = !cmd_empty_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = load && (!two || sub_q);

  always_comb begin
    out_valid_d = out_valid_q;
    sub_d       = sub_q;
    if (load) begin
      out_valid_d = 1'b1;
      sub_d       = two && !sub_q;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind;
      byte_q  <= byte_v;
      run_q   <= run_v;
      total_q <= total_v;
      last_q  <= !two || sub_q;
    end
  end

  assign empty_o        = !out_valid_q;
  assign token_kind_o   = kind_q;
  assign byte_value_o   = byte_q;
  assign run_length_o   = run_q;
  assign total_length_o = total_q;
  assign last_of_step_o = last_q;

endmodule

### sv/rle_token_stream_decoder.sv
// Top level of the run-length token stream decoder.
//
// Decodes a run-length compressed byte stream into tokens: literal bytes,
// (symbol, length) runs, an end token carrying the header's uncompressed
// length, and an error token. One compressed byte is taken per clock cycle
// from the push/full queue side while full is low. A front-end parser handles
// each byte in the cycle it is accepted and, when the byte causes results,
// writes one command into a short command queue (CmdDepth entries). A back
// end turns each command into result items through an output register, so a
// waiting result blocks the next byte only once the command queue is full.
// A byte causes at most two items (the last literal of a block followed by
// its run or end token); that command loads the output register twice, and
// the command queue absorbs the difference. The first result of a byte
// passes through the command queue and then the output register before it
// reaches the result ports. Sustained rate: one byte per cycle, bounded by
// result draining when pop is held low or two-item bytes come back to back.
// full rises only while the command queue is full. A byte with stream_start
// high restarts the parser and is read as header byte 0. The two capacity
// registers sit at byte addresses 0 (output_capacity) and 4 (input_capacity);
// write them only while the block is idle.
module rle_token_stream_decoder #(
  parameter int unsigned CmdDepth = rtsd_pkg::CmdQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // compressed byte side
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte_i,
  input  logic                          stream_start_i,
  // token side
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    token_kind_o,
  output logic [7:0]                    byte_value_o,
  output logic [32:0]                   run_length_o,
  output logic [31:0]                   total_length_o,
  output logic                          last_of_step_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtsd_pkg::ApbAddrW-1:0] paddr,
  input  logic [rtsd_pkg::ApbDataW-1:0] pwdata,
  output logic [rtsd_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  logic [31:0]    out_cap_q, in_cap_q;
  logic           cfg_wr;
  logic           accept;
  logic           cmd_valid, cmd_pop, cmd_empty;
  rtsd_pkg::cmd_t cmd_wr, cmd_rd;

  // Capacity registers; word index comes from paddr[2].
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == rtsd_pkg::RegInputCapacity) ? in_cap_q : out_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cap_q <= '1;
      in_cap_q  <= '1;
    end else if (cfg_wr) begin
      if (paddr[2] == rtsd_pkg::RegOutputCapacity) begin
        out_cap_q <= pwdata;
      end else begin
        in_cap_q <= pwdata;
      end
    end
  end

  // Take a pushed byte whenever the command queue has room.
  assign accept = push && !full;

  rtsd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .in_byte_i         (in_byte_i),
    .stream_start_i    (stream_start_i),
    .output_capacity_i (out_cap_q),
    .input_capacity_i  (in_cap_q),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd_wr)
  );

  rtsd_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_valid),
    .wr_data_i (cmd_wr),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_rd),
    .full_o    (full),
    .empty_o   (cmd_empty)
  );

  rtsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_empty_i    (cmd_empty),
    .cmd_i          (cmd_rd),
    .cmd_pop_o      (cmd_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .token_kind_o   (token_kind_o),
    .byte_value_o   (byte_value_o),
    .run_length_o   (run_length_o),
    .total_length_o (total_length_o),
    .last_of_step_o (last_of_step_o)
  );

endmodule
